// ===== hw/rtl/led_matrix_text_scroller_top_assert.svh =====
// Assertion macros for the text scroller.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef LED_MATRIX_TEXT_SCROLLER_TOP_ASSERT_SVH
`define LED_MATRIX_TEXT_SCROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define LMTS_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a trigger implies a consequence at the same edge.
`define LMTS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a trigger implies a consequence at the next edge.
`define LMTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LMTS_ASSERT(label, cond, msg)
`define LMTS_ASSERT_SAME(label, ante, cons, msg)
`define LMTS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/lmts_pkg.sv =====
package lmts_pkg;

    // Default configuration of the block
    localparam int DEF_MESSAGE_DEPTH   = 64;
    localparam int DEF_GLYPH_COUNT     = 64;
    localparam int DEF_FIRST_CHAR_CODE = 32;

    // Entries in the command and result queues
    localparam int QUEUE_DEPTH = 2;

    // Screen geometry
    localparam int ROW_COUNT = 8;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 8;

    // Glyph layout: three column bytes, then the width byte
    localparam logic [1:0] GLYPH_WIDTH_BYTE = 2'd3;
    localparam logic [1:0] GLYPH_MAX_WIDTH  = 2'd3;

    // Field widths fixed at the ports
    localparam int FUNC_W   = 2;
    localparam int ADDR_W   = 8;
    localparam int DATA_W   = 8;
    localparam int CFG_W    = 7;

    typedef enum logic [FUNC_W-1:0] {
        OP_SCROLL     = 2'd0,
        OP_SCAN       = 2'd1,
        OP_MSG_WRITE  = 2'd2,
        OP_FONT_WRITE = 2'd3
    } op_t;

    // Classified item handed from front to back
    typedef struct packed {
        op_t               op;
        logic              in_range;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [COL_W-1:0] row_pattern;
        logic             message_wrapped;
    } res_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MSG,
        BK_WIDTH,
        BK_COLUMN
    } bk_state_t;

endpackage

// ===== hw/rtl/lmts_fifo.sv =====
module lmts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Advance pointers and count on each transfer
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hw/rtl/lmts_front.sv =====
module lmts_front
    import lmts_pkg::*;
#(
    parameter int MESSAGE_DEPTH = DEF_MESSAGE_DEPTH,
    parameter int GLYPH_COUNT   = DEF_GLYPH_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [FUNC_W-1:0] func,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] data,
    output cmd_t              cmd,
    output logic              cmd_empty,
    input  logic              cmd_pop
);

    localparam int FONT_DEPTH = GLYPH_COUNT * 4;

    cmd_t                 cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_bits;
    logic [31:0]          addr_wide;

    assign addr_wide = 32'(addr);

    // Classify the item and check write addresses against the stores
    always_comb
    begin
        cmd_in.op   = op_t'(func);
        cmd_in.addr = addr;
        cmd_in.data = data;
        case (cmd_in.op)
            OP_MSG_WRITE:  cmd_in.in_range = (addr_wide < MESSAGE_DEPTH);
            OP_FONT_WRITE: cmd_in.in_range = (addr_wide < FONT_DEPTH);
            default:       cmd_in.in_range = 1'b0;
        endcase
    end

    // Hold classified items until the back end takes them
    lmts_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_bits),
        .empty (cmd_empty)
    );

    assign cmd = cmd_t'(cmd_bits);

endmodule

// ===== hw/rtl/lmts_ram.sv =====
module lmts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, register the read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hw/rtl/lmts_back.sv =====
`include "led_matrix_text_scroller_top_assert.svh"

module lmts_back
    import lmts_pkg::*;
#(
    parameter int MESSAGE_DEPTH   = DEF_MESSAGE_DEPTH,
    parameter int GLYPH_COUNT     = DEF_GLYPH_COUNT,
    parameter int FIRST_CHAR_CODE = DEF_FIRST_CHAR_CODE
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [CFG_W-1:0] cfg_data,
    input  cmd_t             cmd,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    input  logic             res_full,
    output logic             res_push,
    output res_t             res_data
);

    localparam int MSG_AW     = $clog2(MESSAGE_DEPTH);
    localparam int LEN_W      = MSG_AW + 1;
    localparam int GW         = $clog2(GLYPH_COUNT);
    localparam int FONT_DEPTH = GLYPH_COUNT * 4;
    localparam int FONT_AW    = GW + 2;

    bk_state_t        state_reg, state_next;
    logic [COL_W-1:0] screen_reg [ROW_COUNT];
    logic [COL_W-1:0] screen_next [ROW_COUNT];
    logic [ROW_W-1:0] scan_reg, scan_next;
    logic [MSG_AW-1:0] pos_reg, pos_next;
    logic [1:0]       col_reg, col_next;
    logic [1:0]       width_reg, width_next;
    logic [GW-1:0]    glyph_reg, glyph_next;
    logic             wrap_reg, wrap_next;
    logic [LEN_W-1:0] len_reg, len_cfg;
    logic [31:0]      cfg_wide;

    logic [LEN_W-1:0]  pos_plus;
    logic [7:0]        glyph_rem;
    logic [GW-1:0]     glyph_new;

    logic               msg_we;
    logic [MSG_AW-1:0]  msg_addr;
    logic [DATA_W-1:0]  msg_rdata;
    logic               font_we;
    logic [FONT_AW-1:0] font_addr;
    logic [DATA_W-1:0]  font_rdata;

    // Clamp the message length when it is written
    assign cfg_wide = 32'(cfg_data);
    assign len_cfg  = (cfg_wide == 32'd0) ? LEN_W'(1) :
                      (cfg_wide > MESSAGE_DEPTH) ? LEN_W'(MESSAGE_DEPTH) :
                      LEN_W'(cfg_wide);

    assign pos_plus = {1'b0, pos_reg} + LEN_W'(1);

    // Map the character code to a glyph: reduce modulo the glyph count
    always_comb
    begin
        glyph_rem = msg_rdata - 8'(FIRST_CHAR_CODE);
        for (int k = 7; k >= 0; k--)
        begin
            if (32'(glyph_rem) >= (GLYPH_COUNT << k))
            begin
                glyph_rem = glyph_rem - 8'(GLYPH_COUNT << k);
            end
        end
        glyph_new = GW'(glyph_rem);
    end

    // Sequence each item and build its result
    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        pos_next   = pos_reg;
        col_next   = col_reg;
        width_next = width_reg;
        glyph_next = glyph_reg;
        wrap_next  = wrap_reg;
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            screen_next[r] = screen_reg[r];
        end
        cmd_pop   = 1'b0;
        res_push  = 1'b0;
        msg_we    = 1'b0;
        msg_addr  = MSG_AW'(cmd.addr);
        font_we   = 1'b0;
        font_addr = FONT_AW'(cmd.addr);
        res_data.message_wrapped = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_SCROLL:
                        begin
                            if (col_reg == width_reg)
                            begin
                                // End of glyph: advance the message position
                                if (pos_plus >= len_reg)
                                begin
                                    pos_next  = '0;
                                    wrap_next = 1'b1;
                                end
                                else
                                begin
                                    pos_next  = MSG_AW'(pos_plus);
                                    wrap_next = 1'b0;
                                end
                                msg_addr   = pos_next;
                                state_next = BK_MSG;
                            end
                            else
                            begin
                                font_addr  = {glyph_reg, col_reg};
                                col_next   = col_reg + 2'd1;
                                state_next = BK_COLUMN;
                            end
                        end
                        OP_SCAN:
                        begin
                            scan_next = scan_reg + ROW_W'(1);
                            res_push  = 1'b1;
                        end
                        OP_MSG_WRITE:
                        begin
                            msg_we   = cmd.in_range;
                            res_push = 1'b1;
                        end
                        OP_FONT_WRITE:
                        begin
                            font_we  = cmd.in_range;
                            res_push = 1'b1;
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            BK_MSG:
            begin
                // Character is in; fetch the glyph's width byte
                glyph_next = glyph_new;
                font_addr  = {glyph_new, GLYPH_WIDTH_BYTE};
                state_next = BK_WIDTH;
            end
            BK_WIDTH:
            begin
                // Load the width, shift and leave the new column blank
                width_next = (font_rdata > 8'(GLYPH_MAX_WIDTH)) ? GLYPH_MAX_WIDTH
                                                                : font_rdata[1:0];
                col_next   = 2'd0;
                for (int r = 0; r < ROW_COUNT; r++)
                begin
                    screen_next[r] = {screen_reg[r][COL_W-2:0], 1'b0};
                end
                res_data.message_wrapped = wrap_reg;
                res_push   = 1'b1;
                state_next = BK_IDLE;
            end
            BK_COLUMN:
            begin
                // Shift and drop the glyph column into rows 1 to 7
                screen_next[0] = {screen_reg[0][COL_W-2:0], 1'b0};
                for (int r = 1; r < ROW_COUNT; r++)
                begin
                    screen_next[r] = {screen_reg[r][COL_W-2:0], font_rdata[r-1]};
                end
                res_push   = 1'b1;
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        res_data.row_index   = scan_next;
        res_data.row_pattern = screen_next[scan_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            scan_reg  <= '0;
            pos_reg   <= '0;
            col_reg   <= '0;
            width_reg <= '0;
            glyph_reg <= '0;
            wrap_reg  <= 1'b0;
            len_reg   <= LEN_W'(1);
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                screen_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            pos_reg   <= pos_next;
            col_reg   <= col_next;
            width_reg <= width_next;
            glyph_reg <= glyph_next;
            wrap_reg  <= wrap_next;
            if (cfg_valid)
            begin
                len_reg <= len_cfg;
            end
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                screen_reg[r] <= screen_next[r];
            end
        end
    end

    lmts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MESSAGE_DEPTH)
    ) u_msg_ram (
        .clk   (clk),
        .we    (msg_we),
        .addr  (msg_addr),
        .wdata (cmd.data),
        .rdata (msg_rdata)
    );

    lmts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (font_we),
        .addr  (font_addr),
        .wdata (cmd.data),
        .rdata (font_rdata)
    );

    `LMTS_ASSERT_SAME(a_push_has_room, res_push, !res_full, "result pushed into a full queue")
    `LMTS_ASSERT_SAME(a_pop_only_idle, cmd_pop, state_reg == BK_IDLE, "command taken while busy")
    `LMTS_ASSERT_NEXT(a_msg_then_width, state_reg == BK_MSG, state_reg == BK_WIDTH, "width fetch skipped")
    `LMTS_ASSERT_SAME(a_width_emits, state_reg == BK_WIDTH || state_reg == BK_COLUMN, res_push, "scroll step gave no result")
    `LMTS_ASSERT(a_width_in_range, width_reg <= GLYPH_MAX_WIDTH && col_reg <= width_reg, "glyph column past glyph width")

endmodule

// ===== hw/rtl/led_matrix_text_scroller_top.sv =====
// Channel   Direction  Handshake       Payload
// input     in         push / full     func, addr, data
// result    out        empty / pop     row_index, row_pattern, message_wrapped
// config    in         cfg_valid/ready cfg_data (message length)
//
// Scan ticks and store writes finish in the executer's idle state; a scroll step
// waits in BK_COLUMN for the registered font RAM read, and one that ends a glyph
// passes BK_MSG and BK_WIDTH for the registered message RAM and then font RAM reads.
// Reset clears the screen, counters and queues at once; the stores are not cleared.
// full rises when the two-entry command queue fills; the executer waits while the
// two-entry result queue is full.
module led_matrix_text_scroller_top
    import lmts_pkg::*;
#(
    parameter int MESSAGE_DEPTH   = DEF_MESSAGE_DEPTH,
    parameter int GLYPH_COUNT     = DEF_GLYPH_COUNT,
    parameter int FIRST_CHAR_CODE = DEF_FIRST_CHAR_CODE
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [FUNC_W-1:0] func,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] data,
    output logic              empty,
    input  logic              pop,
    output logic [ROW_W-1:0]  row_index,
    output logic [COL_W-1:0]  row_pattern,
    output logic              message_wrapped,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data
);

    cmd_t                    cmd;
    logic                    cmd_empty;
    logic                    cmd_pop;
    logic                    res_full;
    logic                    res_push;
    res_t                    res_in;
    res_t                    res_out;
    logic [$bits(res_t)-1:0] res_bits;

    // Accept the length register at any time
    assign cfg_ready = 1'b1;

    lmts_front #(
        .MESSAGE_DEPTH (MESSAGE_DEPTH),
        .GLYPH_COUNT   (GLYPH_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .addr      (addr),
        .data      (data),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop)
    );

    lmts_back #(
        .MESSAGE_DEPTH   (MESSAGE_DEPTH),
        .GLYPH_COUNT     (GLYPH_COUNT),
        .FIRST_CHAR_CODE (FIRST_CHAR_CODE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    // Hold results until the consumer pops them
    lmts_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign res_out         = res_t'(res_bits);
    assign row_index       = res_out.row_index;
    assign row_pattern     = res_out.row_pattern;
    assign message_wrapped = res_out.message_wrapped;

endmodule
